// ===== src/sawc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sawc_pkg;

  // Field widths
  localparam int unsigned TurnW  = 2;
  localparam int unsigned LenW   = 10;
  localparam int unsigned CoordW = 12;
  localparam int unsigned KeyW   = 2 * CoordW;
  localparam int unsigned ProdW  = 2 * CoordW;
  // Table size 2n, with n below 2^LenW
  localparam int unsigned SizeW  = LenW + 1;
  localparam int unsigned BitCntW = $clog2(ProdW);

  localparam logic [LenW-1:0] LenReset = LenW'(512);

  // Headings
  localparam logic [TurnW-1:0] HeadEast  = 2'd0;
  localparam logic [TurnW-1:0] HeadNorth = 2'd1;
  localparam logic [TurnW-1:0] HeadWest  = 2'd2;
  localparam logic [TurnW-1:0] HeadSouth = 2'd3;

  // Sequencer states
  typedef enum logic [7:0] {
    StClear = 8'b0000_0001,
    StIdle  = 8'b0000_0010,
    StMove  = 8'b0000_0100,
    StMul   = 8'b0000_1000,
    StMod   = 8'b0001_0000,
    StRead  = 8'b0010_0000,
    StCmp   = 8'b0100_0000,
    StStep  = 8'b1000_0000
  } state_e;

  // One table slot
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
  } slot_t;

endpackage

`default_nettype wire

// ===== src/sawc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sawc_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== src/self_avoiding_walk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Self-avoiding walk checker. A walk of n = walk_length steps (1..MAX_STEPS;
// zero counts as one, larger values saturate) arrives as one 2-bit relative
// turn per beat, taken when start is high and busy is low. The walk starts at
// (n+1, 3n+1) heading east; until a repeat, each turn moves one lattice step
// and the new point goes into a 2n-slot open-addressing table hashed by
// (x*y) mod 2n. After the n-th turn a single result beat shows self_avoiding_o
// with result_valid_o high for one cycle; the receiver cannot stall it. Each
// item turns and steps, does the 12x12 multiply, a bit-serial remainder of the
// 24-bit product against 2n, one registered table read per probe, then counts
// the step and goes back to idle. The first turn of a walk also inserts the
// start point; turns after a repeat point skip the table. After the last turn,
// after reset and after any walk_length write, the block clears the table one
// slot at a time (2n slots, 1024 after reset by default) with busy high;
// walk_length writes are taken at any time and abort the walk.

module self_avoiding_walk_checker #(
  parameter int unsigned MAX_STEPS = 512
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [sawc_pkg::TurnW-1:0]   turn_i,
  input  wire logic                         walk_length_we_i,
  input  wire logic [sawc_pkg::LenW-1:0]    walk_length_i,
  output logic                              result_valid_o,
  output logic                              self_avoiding_o
);

  localparam int unsigned Depth = 2 * MAX_STEPS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [sawc_pkg::LenW+1:0] MaxStepsW = (sawc_pkg::LenW + 2)'(MAX_STEPS);
  localparam logic [sawc_pkg::BitCntW-1:0] LastBit = sawc_pkg::BitCntW'(sawc_pkg::ProdW - 1);

  sawc_pkg::state_e state_q, state_d;

  logic [sawc_pkg::LenW-1:0]    wl_q, wl_d;
  logic [sawc_pkg::TurnW-1:0]   heading_q, heading_d;
  logic [sawc_pkg::TurnW-1:0]   turn_q, turn_d;
  logic [sawc_pkg::CoordW-1:0]  x_q, x_d, y_q, y_d;
  logic [sawc_pkg::LenW-1:0]    step_q, step_d;
  logic                         ok_q, ok_d;
  logic                         started_q, started_d;
  logic                         start_ins_q, start_ins_d;
  logic [sawc_pkg::ProdW-1:0]   prod_q, prod_d;
  logic [sawc_pkg::SizeW-1:0]   rem_q, rem_d;
  logic [sawc_pkg::BitCntW-1:0] bit_q, bit_d;
  logic [sawc_pkg::SizeW-1:0]   k_q, k_d;
  logic [sawc_pkg::SizeW-1:0]   tries_q, tries_d;
  logic [sawc_pkg::SizeW-1:0]   clr_q, clr_d;
  logic                         res_valid_q, res_valid_d;
  logic                         res_q, res_d;

  logic [sawc_pkg::LenW-1:0]    len_eff;
  logic [sawc_pkg::SizeW-1:0]   size;
  logic [sawc_pkg::SizeW:0]     rem_shift;
  logic [sawc_pkg::SizeW:0]     rem_sub;
  logic [sawc_pkg::SizeW-1:0]   rem_next;
  logic [sawc_pkg::SizeW-1:0]   k_inc;
  logic [sawc_pkg::SizeW-1:0]   tries_inc;
  logic [sawc_pkg::SizeW-1:0]   step_inc;
  logic [sawc_pkg::TurnW-1:0]   head_new;
  logic                         probe_done;

  logic                         ram_we;
  logic [AddrW-1:0]             ram_addr;
  sawc_pkg::slot_t              ram_wdata, ram_rdata;

  // Effective walk length and table size
  always_comb begin
    if (wl_q == '0) begin
      len_eff = sawc_pkg::LenW'(1);
    end else if ((sawc_pkg::LenW + 2)'(wl_q) > MaxStepsW) begin
      len_eff = sawc_pkg::LenW'(MaxStepsW);
    end else begin
      len_eff = wl_q;
    end
  end
  assign size = {len_eff, 1'b0};

  // Bit-serial remainder step: shift in the next product bit, subtract once
  assign rem_shift = {rem_q, prod_q[sawc_pkg::ProdW-1]};
  assign rem_sub   = rem_shift - {1'b0, size};
  assign rem_next  = (rem_shift >= {1'b0, size}) ? sawc_pkg::SizeW'(rem_sub)
                                                 : sawc_pkg::SizeW'(rem_shift);

  assign k_inc     = (k_q + 1'b1 == size) ? '0 : k_q + 1'b1;
  assign tries_inc = tries_q + 1'b1;
  assign step_inc  = {1'b0, step_q} + 1'b1;
  assign head_new  = heading_q + turn_q;

  assign ram_addr = (state_q == sawc_pkg::StClear) ? AddrW'(clr_q) : AddrW'(k_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    heading_d   = heading_q;
    turn_d      = turn_q;
    x_d         = x_q;
    y_d         = y_q;
    step_d      = step_q;
    ok_d        = ok_q;
    started_d   = started_q;
    start_ins_d = start_ins_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    k_d         = k_q;
    tries_d     = tries_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_wdata   = '{valid: 1'b1, key: {x_q, y_q}};
    probe_done  = 1'b0;

    unique case (state_q)
      sawc_pkg::StClear: begin
        // Invalidate one slot per cycle
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (clr_q == size - 1'b1) begin
          state_d = sawc_pkg::StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      sawc_pkg::StIdle: begin
        if (start) begin
          turn_d = turn_i;
          if (!started_q) begin
            // Begin a walk: insert the start point first
            heading_d   = sawc_pkg::HeadEast;
            x_d         = sawc_pkg::CoordW'(len_eff) + 1'b1;
            y_d         = sawc_pkg::CoordW'({len_eff, 1'b0}) + sawc_pkg::CoordW'(len_eff)
                          + 1'b1;
            step_d      = '0;
            ok_d        = 1'b1;
            started_d   = 1'b1;
            start_ins_d = 1'b1;
            state_d     = sawc_pkg::StMul;
          end else begin
            state_d = sawc_pkg::StMove;
          end
        end
      end
      sawc_pkg::StMove: begin
        if (ok_q) begin
          // Turn and take one step
          heading_d = head_new;
          unique case (head_new)
            sawc_pkg::HeadEast:  x_d = x_q + 1'b1;
            sawc_pkg::HeadNorth: y_d = y_q + 1'b1;
            sawc_pkg::HeadWest:  x_d = x_q - 1'b1;
            sawc_pkg::HeadSouth: y_d = y_q - 1'b1;
            default:             x_d = x_q;
          endcase
          state_d = sawc_pkg::StMul;
        end else begin
          state_d = sawc_pkg::StStep;
        end
      end
      sawc_pkg::StMul: begin
        prod_d  = sawc_pkg::ProdW'(x_q) * sawc_pkg::ProdW'(y_q);
        rem_d   = '0;
        bit_d   = '0;
        tries_d = '0;
        state_d = sawc_pkg::StMod;
      end
      sawc_pkg::StMod: begin
        prod_d = prod_q << 1;
        rem_d  = rem_next;
        bit_d  = bit_q + 1'b1;
        if (bit_q == LastBit) begin
          k_d     = rem_next;
          state_d = sawc_pkg::StRead;
        end
      end
      sawc_pkg::StRead: begin
        state_d = sawc_pkg::StCmp;
      end
      sawc_pkg::StCmp: begin
        // Probe: empty slot takes the point, equal point marks a repeat
        if (!ram_rdata.valid) begin
          ram_we     = 1'b1;
          probe_done = 1'b1;
        end else if (ram_rdata.key == {x_q, y_q}) begin
          if (!start_ins_q) begin
            ok_d = 1'b0;
          end
          probe_done = 1'b1;
        end else if (tries_inc == size) begin
          probe_done = 1'b1;
        end else begin
          tries_d = tries_inc;
          k_d     = k_inc;
          state_d = sawc_pkg::StRead;
        end
        if (probe_done) begin
          if (start_ins_q) begin
            start_ins_d = 1'b0;
            state_d     = sawc_pkg::StMove;
          end else begin
            state_d = sawc_pkg::StStep;
          end
        end
      end
      sawc_pkg::StStep: begin
        step_d = sawc_pkg::LenW'(step_inc);
        if (step_inc >= {1'b0, len_eff}) begin
          // Emit the result and clear the table for the next walk
          res_valid_d = 1'b1;
          res_d       = ok_q;
          started_d   = 1'b0;
          clr_d       = '0;
          state_d     = sawc_pkg::StClear;
        end else begin
          state_d = sawc_pkg::StIdle;
        end
      end
      default: begin
        clr_d   = '0;
        state_d = sawc_pkg::StClear;
      end
    endcase

    // Length write aborts the walk and restarts the clear
    if (walk_length_we_i) begin
      wl_d        = walk_length_i;
      started_d   = 1'b0;
      start_ins_d = 1'b0;
      clr_d       = '0;
      state_d     = sawc_pkg::StClear;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sawc_pkg::StClear;
      wl_q        <= sawc_pkg::LenReset;
      heading_q   <= sawc_pkg::HeadEast;
      step_q      <= '0;
      ok_q        <= 1'b1;
      started_q   <= 1'b0;
      start_ins_q <= 1'b0;
      bit_q       <= '0;
      tries_q     <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      heading_q   <= heading_d;
      step_q      <= step_d;
      ok_q        <= ok_d;
      started_q   <= started_d;
      start_ins_q <= start_ins_d;
      bit_q       <= bit_d;
      tries_q     <= tries_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    turn_q <= turn_d;
    x_q    <= x_d;
    y_q    <= y_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    res_q  <= res_d;
  end

  sawc_ram #(
    .WIDTH ($bits(sawc_pkg::slot_t)),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign busy            = (state_q != sawc_pkg::StIdle);
  assign result_valid_o  = res_valid_q;
  assign self_avoiding_o = res_q;

endmodule

`default_nettype wire

// ===== src/sawc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sawc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic walk_length_we_i,
  input wire logic result_valid_o,
  input wire logic self_avoiding_o
);

  // Accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !walk_length_we_i) |=> busy)
    else $error("block not busy after accepting a turn");

  // Length write starts a table clear
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_length_we_i |=> busy)
    else $error("block not busy after a length write");

  // Result comes from work in flight
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // Table clear follows each result
  a_result_then_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy ##1 !result_valid_o)
    else $error("no clear or repeated result after a walk");

  // Result beat carries a known verdict
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(self_avoiding_o))
    else $error("unknown verdict on a result beat");

endmodule

bind self_avoiding_walk_checker sawc_checker u_sawc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .walk_length_we_i (walk_length_we_i),
  .result_valid_o   (result_valid_o),
  .self_avoiding_o  (self_avoiding_o)
);

`default_nettype wire

// ===== tb/tb_self_avoiding_walk_checker.sv =====
`timescale 1ns / 1ps

module tb_self_avoiding_walk_checker;

  localparam int unsigned MaxSteps   = 512;
  localparam int unsigned TableSlots = 2 * MaxSteps;
  // Watchdog limit, well above the slowest expected run
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned RandomItems = 290;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [sawc_pkg::TurnW-1:0]  turn_i = '0;
  logic                        walk_length_we_i = 1'b0;
  logic [sawc_pkg::LenW-1:0]   walk_length_i = '0;
  logic                        result_valid_o;
  logic                        self_avoiding_o;

  self_avoiding_walk_checker #(
    .MAX_STEPS(MaxSteps)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .turn_i           (turn_i),
    .walk_length_we_i (walk_length_we_i),
    .walk_length_i    (walk_length_i),
    .result_valid_o   (result_valid_o),
    .self_avoiding_o  (self_avoiding_o)
  );

  always #10 clk_i = ~clk_i;

  // Walk state mirrored from the block
  int unsigned                  steps_per_walk;
  logic [sawc_pkg::TurnW-1:0]   heading;
  logic [sawc_pkg::CoordW-1:0]  pos_x;
  logic [sawc_pkg::CoordW-1:0]  pos_y;
  logic [sawc_pkg::LenW-1:0]    step_count;
  bit                           walk_ok;
  bit                           walk_started;
  bit                           slot_used [TableSlots];
  logic [sawc_pkg::KeyW-1:0]    slot_key  [TableSlots];

  bit                 verdict_q [$];
  int unsigned        error_count = 0;
  int unsigned        items_sent = 0;

  // Start a fresh walk: empty table, start point, heading east
  function automatic void restart_walk();
    heading      = sawc_pkg::HeadEast;
    pos_x        = sawc_pkg::CoordW'(steps_per_walk + 1);
    pos_y        = sawc_pkg::CoordW'(3 * steps_per_walk + 1);
    step_count   = '0;
    walk_ok      = 1'b1;
    walk_started = 1'b0;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
    end
  endfunction

  function automatic void set_walk_length(input logic [sawc_pkg::LenW-1:0] value);
    steps_per_walk = value;
    if (steps_per_walk == 0) steps_per_walk = 1;
    if (steps_per_walk > MaxSteps) steps_per_walk = MaxSteps;
    restart_walk();
  endfunction

  // Linear probe from (x*y) mod 2n; returns 0 when the point is already there
  function automatic bit record_point();
    int unsigned size;
    int unsigned slot;
    logic [sawc_pkg::KeyW-1:0] key;
    size = 2 * steps_per_walk;
    key  = {pos_x, pos_y};
    slot = (int'(pos_x) * int'(pos_y)) % size;
    for (int unsigned tries = 0; tries < size; tries++) begin
      if (!slot_used[slot]) begin
        slot_used[slot] = 1'b1;
        slot_key[slot]  = key;
        return 1'b1;
      end
      if (slot_key[slot] == key) return 1'b0;
      slot = (slot + 1 == size) ? 0 : slot + 1;
    end
    return 1'b1;
  endfunction

  // Apply one accepted turn and queue the verdict on the last step
  function automatic void advance_walk(input logic [sawc_pkg::TurnW-1:0] t);
    if (!walk_started) begin
      restart_walk();
      void'(record_point());
      walk_started = 1'b1;
    end
    if (walk_ok) begin
      heading = heading + t;
      case (heading)
        sawc_pkg::HeadEast:  pos_x = pos_x + 1'b1;
        sawc_pkg::HeadNorth: pos_y = pos_y + 1'b1;
        sawc_pkg::HeadWest:  pos_x = pos_x - 1'b1;
        default:             pos_y = pos_y - 1'b1;
      endcase
      if (!record_point()) walk_ok = 1'b0;
    end
    step_count = step_count + 1'b1;
    if (step_count >= steps_per_walk) begin
      verdict_q.push_back(walk_ok);
      restart_walk();
    end
  endfunction

  // Send one beat, with an optional idle gap ahead of it
  task automatic send_turn(input logic [sawc_pkg::TurnW-1:0] t, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    turn_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    advance_walk(t);
    items_sent++;
  endtask

  // Drop start and hold until every queued verdict has come out
  task automatic hold_for_verdicts();
    start <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Let a partial walk or the table clear run out before touching the register
  task automatic wait_idle();
    hold_for_verdicts();
    repeat (64 + 8 * steps_per_walk) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_walk_length(input logic [sawc_pkg::LenW-1:0] value);
    walk_length_we_i <= 1'b1;
    walk_length_i    <= value;
    @(posedge clk_i);
    walk_length_we_i <= 1'b0;
    set_walk_length(value);
  endtask

  task automatic send_walk(input logic [sawc_pkg::TurnW-1:0] turns [$]);
    foreach (turns[i]) send_turn(turns[i], 1'b0);
  endtask

  // Pick the next turn of a random walk; style 0 no back turns, 1 anything,
  // 2 monotone staircase (east/north only, always self-avoiding)
  function automatic logic [sawc_pkg::TurnW-1:0] pick_turn(
      input int unsigned style, inout logic [sawc_pkg::TurnW-1:0] gen_head);
    logic [sawc_pkg::TurnW-1:0] t;
    int unsigned r;
    r = $urandom_range(0, 9);
    case (style)
      0: t = (r < 6) ? 2'd0 : ((r < 8) ? 2'd1 : 2'd3);
      1: t = sawc_pkg::TurnW'($urandom_range(0, 3));
      default: begin
        if (r < 5) t = 2'd0;
        else t = (gen_head == sawc_pkg::HeadEast) ? 2'd1 : 2'd3;
      end
    endcase
    gen_head = gen_head + t;
    return t;
  endfunction

  // Check each result beat against the oldest verdict
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (verdict_q.size() == 0) begin
        $error("self_avoiding: no verdict pending, got %0d", self_avoiding_o);
        error_count++;
      end else begin
        bit exp_ok;
        exp_ok = verdict_q.pop_front();
        if (self_avoiding_o !== exp_ok) begin
          $error("self_avoiding: expected %0d, got %0d", exp_ok, self_avoiding_o);
          error_count++;
        end
      end
    end
  end

  // A write mid-walk drops the partial walk
  task automatic test_abort_on_write();
    send_walk('{2'd0, 2'd1, 2'd3});
    wait_idle();
    write_walk_length(sawc_pkg::LenW'(2));
    send_walk('{2'd0, 2'd0});
    wait_idle();
  endtask

  // One-step walks, including the zero length that counts as one
  task automatic test_single_step_walks();
    write_walk_length(sawc_pkg::LenW'(1));
    send_walk('{2'd0, 2'd1, 2'd2, 2'd3});
    wait_idle();
    write_walk_length(sawc_pkg::LenW'(0));
    send_walk('{2'd2, 2'd3});
    wait_idle();
  endtask

  // Back turn onto the previous point, then turns ignored after a repeat
  task automatic test_repeats();
    write_walk_length(sawc_pkg::LenW'(2));
    send_walk('{2'd0, 2'd2, 2'd3, 2'd0});
    wait_idle();
    write_walk_length(sawc_pkg::LenW'(3));
    send_walk('{2'd2, 2'd2, 2'd1});
    wait_idle();
  endtask

  // Closed squares both ways return to the start point
  task automatic test_closed_squares();
    write_walk_length(sawc_pkg::LenW'(4));
    send_walk('{2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd3});
    wait_idle();
  endtask

  // Saturated length: one full staircase walk of the largest size
  task automatic test_longest_walk();
    logic [sawc_pkg::TurnW-1:0] gen_head;
    bit burst;
    write_walk_length(sawc_pkg::LenW'(1023));
    gen_head = sawc_pkg::HeadEast;
    for (int unsigned i = 0; i < MaxSteps; i++) begin
      if (i % 64 == 0) burst = $urandom_range(0, 1);
      send_turn(pick_turn(2, gen_head), burst);
    end
    wait_idle();
  endtask

  // Random lengths and walks, mostly short
  task automatic test_random_walks();
    int unsigned first_item;
    int unsigned r;
    int unsigned len;
    int unsigned walks;
    int unsigned style;
    bit burst;
    logic [sawc_pkg::TurnW-1:0] gen_head;
    first_item = items_sent;
    while (items_sent - first_item < RandomItems) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(1, 12);
      else if (r < 9) len = $urandom_range(13, 40);
      else len = $urandom_range(41, 100);
      write_walk_length(sawc_pkg::LenW'(len));
      walks = $urandom_range(2, 6);
      repeat (walks) begin
        r = $urandom_range(0, 9);
        style = (r < 6) ? 0 : ((r < 8) ? 1 : 2);
        burst = ($urandom_range(0, 3) == 0);
        gen_head = sawc_pkg::HeadEast;
        for (int unsigned i = 0; i < len; i++) begin
          send_turn(pick_turn(style, gen_head), burst);
          if ($urandom_range(0, 39) == 0) hold_for_verdicts();
        end
      end
      wait_idle();
    end
  endtask

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    set_walk_length(sawc_pkg::LenReset);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_abort_on_write();
    test_single_step_walks();
    test_repeats();
    test_closed_squares();
    test_longest_walk();
    test_random_walks();

    // Drain, then give the block time to show any stray beat
    hold_for_verdicts();
    repeat (64 + 8 * steps_per_walk) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
